### rtl/core/tcpos_pkg.sv
// Shared types and constants for the TCP option scanner.
// No dependencies; imported by tcpos_scan, tcp_option_scanner and sim/tb.sv.
package tcpos_pkg;

   // Option kinds with special handling
   localparam logic [7:0] KIND_EOL    = 8'd0;
   localparam logic [7:0] KIND_NOP    = 8'd1;
   localparam logic [7:0] KIND_MSS    = 8'd2;
   localparam logic [7:0] KIND_WSCALE = 8'd3;

   // Smallest legal option length (kind + length bytes)
   localparam logic [7:0] LEN_MIN = 8'd2;

   // Values that mean "not captured"
   localparam logic [15:0] MSS_ABSENT   = 16'hffff;
   localparam logic [7:0]  SCALE_ABSENT = 8'hff;

   // Stream widths
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 56;

   typedef struct packed {
      logic [7:0]  option_kind;
      logic        kind_valid;
      logic        summary_last;
      logic [15:0] mss_value;
      logic        mss_present;
      logic [7:0]  scale_value;
      logic        scale_present;
      logic [15:0] window_out;
      logic        had_options;
   } result_type;

   // Results raised by one request: kind result first, then summary
   typedef struct packed {
      logic       kind_hit;
      result_type kind_res;
      logic       sum_hit;
      result_type sum_res;
   } scan_out_type;

endpackage

### rtl/core/tcpos_scan.sv
// Option walk state machine: consumes one byte per accepted request and
// raises up to two results. Depends on tcpos_pkg.
module tcpos_scan
   import tcpos_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  logic [7:0]   option_byte,
   input  logic         last_byte,
   input  logic         no_options,
   input  logic [15:0]  window,
   output scan_out_type scan_out
);

   typedef enum logic [1:0] {
      PH_KIND,
      PH_LEN,
      PH_DATA,
      PH_STOP
   } phase_type;

   localparam logic [1:0] POS_HOLD = 2'd2;

   phase_type   phase_ff, phase_in, phase_upd;
   logic [7:0]  kind_ff, kind_in, kind_upd;
   logic [7:0]  left_ff, left_in, left_upd;
   logic [1:0]  pos_ff, pos_in, pos_upd;
   logic [15:0] mss_ff, mss_in, mss_upd;
   logic [7:0]  scale_ff, scale_in, scale_upd;
   logic [7:0]  high_ff, high_in, high_upd;
   logic        kind_hit;
   logic        sum_hit;

   always_comb begin
      phase_upd = phase_ff;
      kind_upd  = kind_ff;
      left_upd  = left_ff;
      pos_upd   = pos_ff;
      mss_upd   = mss_ff;
      scale_upd = scale_ff;
      high_upd  = high_ff;
      kind_hit  = 1'b0;
      if (accept && !no_options) begin
         case (phase_ff)
            PH_KIND: begin
               kind_hit = 1'b1;
               if (option_byte == KIND_EOL) begin
                  phase_upd = PH_STOP;
               end else if (option_byte != KIND_NOP) begin
                  kind_upd  = option_byte;
                  phase_upd = PH_LEN;
               end
            end
            PH_LEN: begin
               if (option_byte < LEN_MIN) begin
                  phase_upd = PH_STOP;
               end else begin
                  left_upd  = option_byte - LEN_MIN;
                  pos_upd   = 2'd0;
                  phase_upd = (option_byte == LEN_MIN) ? PH_KIND : PH_DATA;
               end
            end
            PH_DATA: begin
               if (kind_ff == KIND_MSS) begin
                  if (pos_ff == 2'd0) begin
                     high_upd = option_byte;
                  end else if (pos_ff == 2'd1) begin
                     mss_upd = {high_ff, option_byte};
                  end
               end else if (kind_ff == KIND_WSCALE && pos_ff == 2'd0) begin
                  scale_upd = option_byte;
               end
               if (pos_ff != POS_HOLD) begin
                  pos_upd = pos_ff + 2'd1;
               end
               left_upd = left_ff - 8'd1;
               if (left_ff == 8'd1) begin
                  phase_upd = PH_KIND;
               end
            end
            default: begin
               // stopped: ignore bytes until the end of the area
            end
         endcase
      end

      sum_hit = accept && (no_options || last_byte);

      // end of area: clear the walk after the summary has sampled it
      if (sum_hit) begin
         phase_in = PH_KIND;
         kind_in  = 8'd0;
         left_in  = 8'd0;
         pos_in   = 2'd0;
         mss_in   = MSS_ABSENT;
         scale_in = SCALE_ABSENT;
         high_in  = 8'd0;
      end else begin
         phase_in = phase_upd;
         kind_in  = kind_upd;
         left_in  = left_upd;
         pos_in   = pos_upd;
         mss_in   = mss_upd;
         scale_in = scale_upd;
         high_in  = high_upd;
      end
   end

   always_comb begin
      scan_out = '0;
      scan_out.kind_hit             = kind_hit;
      scan_out.kind_res.option_kind = option_byte;
      scan_out.kind_res.kind_valid  = 1'b1;

      scan_out.sum_hit                = sum_hit;
      scan_out.sum_res.summary_last   = 1'b1;
      scan_out.sum_res.mss_value      = no_options ? MSS_ABSENT : mss_upd;
      scan_out.sum_res.scale_value    = no_options ? SCALE_ABSENT : scale_upd;
      scan_out.sum_res.mss_present    = !no_options && (mss_upd != MSS_ABSENT);
      scan_out.sum_res.scale_present  = !no_options && (scale_upd != SCALE_ABSENT);
      scan_out.sum_res.window_out     = window;
      scan_out.sum_res.had_options    = !no_options;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_KIND;
         kind_ff  <= 8'd0;
         left_ff  <= 8'd0;
         pos_ff   <= 2'd0;
         mss_ff   <= MSS_ABSENT;
         scale_ff <= SCALE_ABSENT;
         high_ff  <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         left_ff  <= left_in;
         pos_ff   <= pos_in;
         mss_ff   <= mss_in;
         scale_ff <= scale_in;
         high_ff  <= high_in;
      end
   end

endmodule

### rtl/core/tcp_option_scanner.sv
// Top level of the TCP option scanner: request stream in, result queue out.
// Depends on tcpos_pkg and tcpos_scan.
//
// The scanner walks a TCP option area one byte per request and reports each
// option kind it meets, then a summary (MSS, window scale, echoed window) on
// the byte flagged by req_tlast or on a request with req_tuser (no options)
// set. A request is taken while req_tready is high; its results go into a
// three-entry result queue that drains one result per cycle while rsp_tready
// is high. req_tready is high while the queue holds at most one result, so
// plain option bytes flow at one request per clock while the receiver keeps
// up; a request that raises both a kind result and a summary takes two queue
// slots. Results are registered in the queue before they reach rsp_tdata.
module tcp_option_scanner
   import tcpos_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [7:0] option_byte, [23:8] window
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,   // last_byte
   input  logic                  req_tuser,   // no_options

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] option_kind, [23:8] mss_value, [24] mss_present,
   // [32:25] scale_value, [33] scale_present, [49:34] window_out,
   // [50] had_options, [55:51] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,   // summary_last
   output logic                  rsp_tuser    // kind_valid
);

   localparam int QUEUE_DEPTH = 3;

   logic         req_accept;
   logic         rsp_accept;
   scan_out_type scan_out;

   result_type   queue_ff [QUEUE_DEPTH];
   logic [1:0]   head_ff, head_in;
   logic [1:0]   tail_ff, tail_in;
   logic [1:0]   count_ff, count_in;
   logic [1:0]   tail_next;
   logic [1:0]   push_count;
   result_type   first_res;
   result_type   head_res;

   // step a queue pointer, wrapping at the queue depth
   function automatic logic [1:0] ptr_step(input logic [1:0] ptr);
      return (ptr == 2'(QUEUE_DEPTH - 1)) ? 2'd0 : ptr + 2'd1;
   endfunction

   // hold off new requests until two free slots are guaranteed
   assign req_tready = (count_ff <= 2'd1);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_tvalid && rsp_tready;

   tcpos_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .option_byte (req_tdata[7:0]),
      .last_byte   (req_tlast),
      .no_options  (req_tuser),
      .window      (req_tdata[23:8]),
      .scan_out    (scan_out)
   );

   always_comb begin
      push_count = 2'(scan_out.kind_hit) + 2'(scan_out.sum_hit);
      first_res  = scan_out.kind_hit ? scan_out.kind_res : scan_out.sum_res;
      tail_next  = ptr_step(tail_ff);
      tail_in    = tail_ff;
      if (push_count == 2'd1) begin
         tail_in = tail_next;
      end else if (push_count == 2'd2) begin
         tail_in = ptr_step(tail_next);
      end
      head_in  = rsp_accept ? ptr_step(head_ff) : head_ff;
      count_in = count_ff - 2'(rsp_accept) + push_count;
   end

   // payload slots: write the first result at the tail, a second one after it
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         queue_ff[tail_ff] <= first_res;
      end
      if (push_count == 2'd2) begin
         queue_ff[tail_next] <= scan_out.sum_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 2'd0;
         tail_ff  <= 2'd0;
         count_ff <= 2'd0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   assign head_res   = queue_ff[head_ff];
   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tlast  = head_res.summary_last;
   assign rsp_tuser  = head_res.kind_valid;
   assign rsp_tdata  = {5'd0,
                        head_res.had_options,
                        head_res.window_out,
                        head_res.scale_present,
                        head_res.scale_value,
                        head_res.mss_present,
                        head_res.mss_value,
                        head_res.option_kind};

   // the queue never overfills
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(QUEUE_DEPTH))
      else $error("result queue count exceeds depth");

   // every request that ends the area leaves a result waiting
   a_summary_queued: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_tuser || req_tlast)) |=> rsp_tvalid)
      else $error("end-of-area request left no result queued");

   // a summary never reports an option kind
   a_summary_shape: assert property (@(posedge clock) disable iff (reset)
      (scan_out.sum_hit) |-> (scan_out.sum_res.summary_last
                              && !scan_out.sum_res.kind_valid))
      else $error("summary result marked as kind result");

   // results only appear in response to accepted requests
   a_push_needs_accept: assert property (@(posedge clock) disable iff (reset)
      (push_count != 2'd0) |-> req_accept)
      else $error("result pushed without an accepted request");

endmodule

### sim/tb.sv
// Self-checking testbench for tcp_option_scanner: drives option-area requests
// and checks every result against a cycle-free predictor of the option walk.
// Depends on tcpos_pkg and the scanner RTL only.
module tb;
   import tcpos_pkg::*;

   localparam int ITEM_TARGET  = 1050;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 20;
   localparam int RESET_CYCLES = 11;

   // One request as the generator sees it; wait_drain holds it back until
   // every outstanding result has come out of the scanner.
   typedef struct {
      logic [7:0]  option_byte;
      logic        last_byte;
      logic        no_options;
      logic [15:0] window;
      logic        wait_drain;
   } opt_request_type;

   // Where the option walk stands
   typedef enum logic [1:0] {
      WALK_KIND,
      WALK_LEN,
      WALK_DATA,
      WALK_STOP
   } walk_state_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // [7:0] option_byte, [23:8] window
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tlast  = 1'b0;   // last_byte
   logic                  req_tuser  = 1'b0;   // no_options
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [7:0] option_kind, [23:8] mss_value, [24] mss_present,
   // [32:25] scale_value, [33] scale_present, [49:34] window_out,
   // [50] had_options, [55:51] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;           // summary_last
   logic                  rsp_tuser;           // kind_valid

   opt_request_type request_q[$];     // requests not yet accepted
   result_type      scan_results_q[$]; // results predicted, not yet seen
   int              accepted_count = 0;
   int              mismatch_count = 0;
   int              cycle_count    = 0;

   // Predictor copy of the walk
   walk_state_type walk_state;
   logic [7:0]     walk_kind;
   logic [7:0]     skip_left;
   logic [1:0]     data_idx;
   logic [15:0]    mss_hold;
   logic [7:0]     scale_hold;
   logic [7:0]     mss_upper;

   tcp_option_scanner u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Bound the run; a hang anywhere lands here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Idle rates move with progress: sender light / receiver heavy first,
   // then swapped, then full throughput on both sides.
   function automatic int send_idle_pct();
      if (accepted_count < 350) return 17;
      if (accepted_count < 700) return 84;
      return 0;
   endfunction

   function automatic int recv_idle_pct();
      if (accepted_count < 350) return 84;
      if (accepted_count < 700) return 17;
      return 0;
   endfunction

   task automatic clear_walk();
      walk_state = WALK_KIND;
      walk_kind  = '0;
      skip_left  = '0;
      data_idx   = '0;
      mss_hold   = MSS_ABSENT;
      scale_hold = SCALE_ABSENT;
      mss_upper  = '0;
   endtask

   // Advance the walk by one accepted request and queue the results it raises:
   // a kind result when a kind byte is consumed, then a summary at area end.
   task automatic predict_request(input opt_request_type r);
      result_type res;
      if (r.no_options) begin
         // empty area wins over the byte and the last flag
         res               = '0;
         res.summary_last  = 1'b1;
         res.mss_value     = MSS_ABSENT;
         res.scale_value   = SCALE_ABSENT;
         res.window_out    = r.window;
         scan_results_q.push_back(res);
         clear_walk();
         return;
      end
      case (walk_state)
         WALK_KIND: begin
            res             = '0;
            res.option_kind = r.option_byte;
            res.kind_valid  = 1'b1;
            scan_results_q.push_back(res);
            if (r.option_byte == KIND_EOL) begin
               walk_state = WALK_STOP;
            end else if (r.option_byte != KIND_NOP) begin
               walk_kind  = r.option_byte;
               walk_state = WALK_LEN;
            end
         end
         WALK_LEN: begin
            if (r.option_byte < LEN_MIN) begin
               walk_state = WALK_STOP;
            end else begin
               skip_left  = r.option_byte - LEN_MIN;
               data_idx   = '0;
               walk_state = (skip_left == 0) ? WALK_KIND : WALK_DATA;
            end
         end
         WALK_DATA: begin
            // MSS lands only once both of its bytes have arrived
            if (walk_kind == KIND_MSS) begin
               if (data_idx == 2'd0) mss_upper = r.option_byte;
               else if (data_idx == 2'd1) mss_hold = {mss_upper, r.option_byte};
            end else if (walk_kind == KIND_WSCALE && data_idx == 2'd0) begin
               scale_hold = r.option_byte;
            end
            if (data_idx < 2'd2) data_idx = data_idx + 2'd1;
            skip_left = skip_left - 8'd1;
            if (skip_left == 0) walk_state = WALK_KIND;
         end
         default: ;
      endcase
      if (r.last_byte) begin
         res               = '0;
         res.summary_last  = 1'b1;
         res.mss_value     = mss_hold;
         res.mss_present   = (mss_hold != MSS_ABSENT);
         res.scale_value   = scale_hold;
         res.scale_present = (scale_hold != SCALE_ABSENT);
         res.window_out    = r.window;
         res.had_options   = 1'b1;
         scan_results_q.push_back(res);
         clear_walk();
      end
   endtask

   // Request driver: hold a presented request until it is taken, then pick
   // the next one or idle.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
         req_tuser  <= 1'b0;
         clear_walk();
      end else begin
         if (req_tvalid && req_tready) begin
            predict_request(request_q.pop_front());
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (request_q.size() > 0
                && !(request_q[0].wait_drain && scan_results_q.size() > 0)
                && $urandom_range(99) >= send_idle_pct()) begin
               req_tvalid <= 1'b1;
               req_tdata  <= {request_q[0].window, request_q[0].option_byte};
               req_tlast  <= request_q[0].last_byte;
               req_tuser  <= request_q[0].no_options;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // Result monitor: compare each taken result with the oldest prediction.
   always @(posedge clock) begin : rsp_check
      result_type got;
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got               = '0;
            got.option_kind   = rsp_tdata[7:0];
            got.mss_value     = rsp_tdata[23:8];
            got.mss_present   = rsp_tdata[24];
            got.scale_value   = rsp_tdata[32:25];
            got.scale_present = rsp_tdata[33];
            got.window_out    = rsp_tdata[49:34];
            got.had_options   = rsp_tdata[50];
            got.summary_last  = rsp_tlast;
            got.kind_valid    = rsp_tuser;
            if (scan_results_q.size() == 0) begin
               $error("result with nothing pending: kind 0x%0h summary %0b",
                      got.option_kind, got.summary_last);
               mismatch_count++;
            end else begin
               want = scan_results_q.pop_front();
               check_field("option_kind", 16'(want.option_kind),
                           16'(got.option_kind));
               check_field("kind_valid", 16'(want.kind_valid),
                           16'(got.kind_valid));
               check_field("summary_last", 16'(want.summary_last),
                           16'(got.summary_last));
               check_field("mss_value", want.mss_value, got.mss_value);
               check_field("mss_present", 16'(want.mss_present),
                           16'(got.mss_present));
               check_field("scale_value", 16'(want.scale_value),
                           16'(got.scale_value));
               check_field("scale_present", 16'(want.scale_present),
                           16'(got.scale_present));
               check_field("window_out", want.window_out, got.window_out);
               check_field("had_options", 16'(want.had_options),
                           16'(got.had_options));
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct());
      end
   end

   task automatic add_request(input logic [7:0] b, input logic last,
                              input logic none, input logic drain);
      opt_request_type r;
      r.option_byte = b;
      r.last_byte   = last;
      r.no_options  = none;
      r.window      = 16'($urandom_range(65535));
      r.wait_drain  = drain;
      request_q.push_back(r);
   endtask

   // Queue an option area, flagging its final byte as last.
   task automatic add_area(input logic [7:0] bytes[$], input logic drain);
      for (int i = 0; i < bytes.size(); i++)
         add_request(bytes[i], i == bytes.size() - 1, 1'b0, drain && i == 0);
   endtask

   // Build one option list with random content, some options with odd lengths.
   task automatic build_options(output logic [7:0] area[$]);
      int n_opts;
      int pick;
      int len;
      area = {};
      n_opts = $urandom_range(1, 6);
      for (int i = 0; i < n_opts; i++) begin
         pick = $urandom_range(99);
         if (pick < 15) begin
            area.push_back(KIND_NOP);
         end else if (pick < 25) begin
            // end of list, then padding the scanner must ignore
            area.push_back(KIND_EOL);
            repeat ($urandom_range(0, 3)) area.push_back(8'($urandom_range(255)));
         end else begin
            if (pick < 45) begin
               area.push_back(KIND_MSS);
               len = ($urandom_range(9) == 0) ? $urandom_range(0, 6) : 4;
            end else if (pick < 65) begin
               area.push_back(KIND_WSCALE);
               len = ($urandom_range(9) == 0) ? $urandom_range(0, 5) : 3;
            end else if (pick < 95) begin
               area.push_back(8'($urandom_range(4, 255)));
               len = $urandom_range(2, 10);
            end else begin
               // odd lengths: below the minimum, or a long skip
               area.push_back(8'($urandom_range(4, 255)));
               len = $urandom_range(0, 255);
            end
            area.push_back(8'(len));
            for (int j = 2; j < len; j++) area.push_back(8'($urandom_range(255)));
         end
      end
   endtask

   // Stimulus, then wait for the scanner to drain and report.
   initial begin
      logic [7:0] area[$];
      int         pick;
      int         cut;
      int         packets;

      // MSS, window scale, NOP and an end-of-list kind on the last byte
      area = {8'h02, 8'h04, 8'h05, 8'hb4, 8'h03, 8'h03, 8'h0e, 8'h01, 8'h00};
      add_area(area, 1'b0);
      // short MSS, short scale, length below minimum, ignored tail byte
      area = {8'h02, 8'h03, 8'haa, 8'h03, 8'h02, 8'h80, 8'h01, 8'h44};
      add_area(area, 1'b0);
      // scale overwritten by absent value; kind byte on the last position
      area = {8'h03, 8'h03, 8'h04, 8'h03, 8'h03, 8'hff, 8'h22};
      add_area(area, 1'b0);
      // MSS cut off by an empty-area request; wait for a full drain first
      area = {8'h02, 8'h04, 8'h12};
      for (int i = 0; i < area.size(); i++)
         add_request(area[i], 1'b0, 1'b0, i == 0);
      add_request(8'hff, 1'b1, 1'b1, 1'b0);

      packets = 0;
      while (request_q.size() < ITEM_TARGET + 28) begin
         pick = $urandom_range(99);
         packets++;
         if (pick < 8) begin
            // empty option area
            add_request(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1, 1'b0);
         end else if (pick < 18) begin
            // noise: random bytes with random last flags
            cut = $urandom_range(1, 12);
            for (int i = 0; i < cut; i++)
               add_request(8'($urandom_range(255)),
                           i == cut - 1 || $urandom_range(7) == 0, 1'b0, 1'b0);
         end else begin
            build_options(area);
            // truncate some areas mid-option
            if ($urandom_range(9) == 0) begin
               cut = $urandom_range(1, area.size());
               while (area.size() > cut) void'(area.pop_back());
            end
            if ($urandom_range(9) == 0) begin
               // abort the area with an empty-area request instead of last
               for (int i = 0; i < area.size(); i++)
                  add_request(area[i], 1'b0, 1'b0, 1'b0);
               add_request(8'($urandom_range(255)), 1'($urandom_range(1)),
                           1'b1, 1'b0);
            end else begin
               add_area(area, packets % 25 == 0);
            end
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (request_q.size() > 0 || req_tvalid || scan_results_q.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && scan_results_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
